// ----- design/cwt_pkg.sv -----
// ----------------------------------------------------------------------------
// cwt_pkg: shared definitions for the credential whitelist table
// Sizes, request and status codes, character helpers and preset values.
// ----------------------------------------------------------------------------
package cwt_pkg;

  // Table geometry
  localparam int ENTRIES   = 16;
  localparam int ID_CHARS  = 8;
  localparam int PIN_CHARS = 5;

  // Port field widths
  localparam int ID_IN_W  = 64;
  localparam int PIN_IN_W = 40;
  localparam int SLOT_W   = 4;
  localparam int STS_W    = 3;
  localparam int OP_W     = 2;

  // Derived storage widths
  localparam int ID_W  = ID_CHARS * 8;
  localparam int PIN_W = PIN_CHARS * 8;
  localparam int ENT_W = ID_W + PIN_W;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // The character that is never a valid ID character
  localparam logic [7:0] CH_N = 8'h6E;

  // Preset credentials, first character in the top byte
  localparam logic [63:0] PRESET_ID0  = 64'h3435_3137_3636_3031; // "45176601"
  localparam logic [63:0] PRESET_ID1  = 64'h3030_3030_3030_3030; // "00000000"
  localparam logic [39:0] PRESET_PIN0 = 40'h31_3131_3131;        // "11111"
  localparam logic [39:0] PRESET_PIN1 = 40'h30_3030_3030;        // "00000"

  typedef enum logic [OP_W-1:0] {
    OP_CHECK  = 2'd0,
    OP_VERIFY = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK           = 3'd0,
    STS_NOT_FOUND    = 3'd1,
    STS_PIN_MISMATCH = 3'd2,
    STS_FULL         = 3'd3,
    STS_BAD_FORMAT   = 3'd4,
    STS_PRESENT      = 3'd5
  } status_e;

  // Any ID character equal to 'n'
  function automatic logic id_has_n(input logic [ID_W-1:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < ID_CHARS; k++) begin
      if (v[8*k +: 8] == CH_N) hit = 1'b1;
    end
    return hit;
  endfunction

  // Any of the leading PIN_CHARS-1 PIN characters equal to 'n'
  function automatic logic pin_has_n(input logic [PIN_W-1:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 1; k < PIN_CHARS; k++) begin
      if (v[8*k +: 8] == CH_N) hit = 1'b1;
    end
    return hit;
  endfunction

  // Preset ID for slot 0 or 1, cut to ID_CHARS characters
  function automatic logic [ID_W-1:0] preset_id(input logic sel);
    logic [63:0]     src;
    logic [ID_W-1:0] v;
    src = sel ? PRESET_ID1 : PRESET_ID0;
    v   = '0;
    for (int k = 0; k < ID_CHARS; k++) begin
      v = (v << 8) | ID_W'(src[8*(7-k) +: 8]);
    end
    return v;
  endfunction

  // Preset PIN for slot 0 or 1, last character repeated past five
  function automatic logic [PIN_W-1:0] preset_pin(input logic sel);
    logic [39:0]      src;
    logic [PIN_W-1:0] v;
    int               c;
    src = sel ? PRESET_PIN1 : PRESET_PIN0;
    v   = '0;
    for (int k = 0; k < PIN_CHARS; k++) begin
      c = (k < 5) ? k : 4;
      v = (v << 8) | PIN_W'(src[8*(4-c) +: 8]);
    end
    return v;
  endfunction

endpackage

// ----- design/cwt_req_if.sv -----
// ----------------------------------------------------------------------------
// cwt_req_if: request channel
// Valid/ready channel carrying one request beat: opcode, ID and PIN.
// ----------------------------------------------------------------------------
interface cwt_req_if;
  logic                         valid;
  logic                         ready;
  logic [cwt_pkg::OP_W-1:0]     opcode;
  logic [cwt_pkg::ID_IN_W-1:0]  id_chars;
  logic [cwt_pkg::PIN_IN_W-1:0] pin_chars;

  modport source (output valid, output opcode, output id_chars, output pin_chars,
                  input ready);
  modport sink   (input valid, input opcode, input id_chars, input pin_chars,
                  output ready);
endinterface

// ----- design/cwt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cwt_rsp_if: response channel
// Valid/ready channel carrying one result beat: ok, status and slot.
// ----------------------------------------------------------------------------
interface cwt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [cwt_pkg::STS_W-1:0]  status;
  logic [cwt_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output ok, output status, output slot, input ready);
  modport sink   (input valid, input ok, input status, input slot, output ready);
endinterface

// ----- design/cwt_mem.sv -----
// ----------------------------------------------------------------------------
// cwt_mem: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cwt_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 104
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/credential_whitelist_table.sv -----
// ----------------------------------------------------------------------------
// credential_whitelist_table: ID/PIN whitelist with check, verify, add, remove
// Credentials live in one RAM; a controller scans it and writes back.
// ----------------------------------------------------------------------------
// Each request beat is served by a linear scan of the credential RAM, one slot
// per cycle through its single read port, followed by a resolve step that
// decides the status and performs the write for add, and a reply step that
// loads the result register. A request is accepted only in the idle state, so
// the block takes no new request until the previous one has passed its reply
// step. The next request is accepted while the previous result still waits in
// the output register; it is held at the reply step until that register frees.
// Used marks sit in flip-flops and slots 0 and 1 read their preset credentials
// until first written, so no clearing pass follows reset.
// When several slots hold the same ID the lowest one wins; slot reports the low
// four bits of the index and is zero when no slot is involved.
// ----------------------------------------------------------------------------
module credential_whitelist_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  cwt_req_if.sink   req_i,
  cwt_rsp_if.source rsp_o
);

  localparam int ENTRIES = cwt_pkg::ENTRIES;
  localparam int IDX_W   = cwt_pkg::IDX_W;
  localparam int CNT_W   = cwt_pkg::CNT_W;
  localparam int ID_W    = cwt_pkg::ID_W;
  localparam int PIN_W   = cwt_pkg::PIN_W;
  localparam int ENT_W   = cwt_pkg::ENT_W;
  localparam int SLOT_W  = cwt_pkg::SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_REPLY
  } state_e;

  state_e                state_q, state_d;
  cwt_pkg::op_e          op_q, op_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [PIN_W-1:0]      pin_q, pin_d;
  logic                  id_bad_q, id_bad_d;
  logic                  pin_bad_q, pin_bad_d;
  logic [CNT_W-1:0]      rd_cnt_q, rd_cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic [PIN_W-1:0]      hit_pin_q, hit_pin_d;
  logic                  free_q, free_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]    used_q, used_d;
  logic [1:0]            preset_q, preset_d;
  cwt_pkg::status_e      res_sts_q, res_sts_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic                  res_has_q, res_has_d;
  logic                  rsp_vld_q, rsp_vld_d;
  cwt_pkg::status_e      rsp_sts_q, rsp_sts_d;
  logic [SLOT_W-1:0]     rsp_slot_q, rsp_slot_d;

  logic                  mem_we;
  logic                  mem_re;
  logic [ENT_W-1:0]      mem_rdata;
  logic                  ent_preset;
  logic [ID_W-1:0]       ent_id;
  logic [PIN_W-1:0]      ent_pin;
  logic [63:0]           pin_ext;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  // Credential RAM: {id, pin} per slot
  cwt_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx_q),
    .wdata_i ({id_q, pin_q}),
    .re_i    (mem_re),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Read issue while scanning; write on a successful add
  assign mem_re = (state_q == S_SCAN) && (rd_cnt_q != CNT_W'(ENTRIES));
  assign mem_we = (state_q == S_RESOLVE) && (op_q == cwt_pkg::OP_ADD) && !id_bad_q &&
                  !pin_bad_q && !hit_q && free_q;

  // Slots 0 and 1 read their preset until first written
  assign ent_preset = (preset_q[0] && (cmp_idx_q == IDX_W'(0))) ||
                      (preset_q[1] && (cmp_idx_q == IDX_W'(1)));
  assign ent_id  = ent_preset ? cwt_pkg::preset_id(cmp_idx_q[0]) : mem_rdata[ENT_W-1:PIN_W];
  assign ent_pin = ent_preset ? cwt_pkg::preset_pin(cmp_idx_q[0]) : mem_rdata[PIN_W-1:0];

  // Input PIN field, zero-extended then cut to the stored width
  assign pin_ext = {{(64 - cwt_pkg::PIN_IN_W){1'b0}}, req_i.pin_chars};

  // Slot index into the result field width
  assign slot_ext = {{SLOT_W{1'b0}}, res_idx_q};

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    pin_d      = pin_q;
    id_bad_d   = id_bad_q;
    pin_bad_d  = pin_bad_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_pin_d  = hit_pin_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    used_d     = used_q;
    preset_d   = preset_q;
    res_sts_d  = res_sts_q;
    res_idx_d  = res_idx_q;
    res_has_d  = res_has_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    rsp_sts_d  = rsp_sts_q;
    rsp_slot_d = rsp_slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d      = cwt_pkg::op_e'(req_i.opcode);
          id_d      = req_i.id_chars[ID_W-1:0];
          pin_d     = pin_ext[PIN_W-1:0];
          id_bad_d  = cwt_pkg::id_has_n(req_i.id_chars[ID_W-1:0]);
          pin_bad_d = cwt_pkg::pin_has_n(pin_ext[PIN_W-1:0]);
          rd_cnt_d  = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          state_d   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (mem_re) begin
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[IDX_W-1:0];
        end
        // Compare the slot read in the previous cycle
        if (cmp_vld_q) begin
          if (!hit_q && !id_bad_q && used_q[cmp_idx_q] && (ent_id == id_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_pin_d = ent_pin;
          end
          if (!free_q && !used_q[cmp_idx_q]) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (cmp_idx_q == IDX_W'(ENTRIES - 1)) state_d = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        res_sts_d = cwt_pkg::STS_OK;
        res_idx_d = hit_idx_q;
        res_has_d = hit_q;
        case (op_q)
          cwt_pkg::OP_CHECK: begin
            if (!hit_q) res_sts_d = cwt_pkg::STS_NOT_FOUND;
          end
          cwt_pkg::OP_VERIFY: begin
            if (!hit_q) res_sts_d = cwt_pkg::STS_NOT_FOUND;
            else if ((pin_q != hit_pin_q) || pin_bad_q) res_sts_d = cwt_pkg::STS_PIN_MISMATCH;
          end
          cwt_pkg::OP_ADD: begin
            res_has_d = 1'b0;
            if (id_bad_q || pin_bad_q) begin
              res_sts_d = cwt_pkg::STS_BAD_FORMAT;
            end else if (hit_q) begin
              res_sts_d = cwt_pkg::STS_PRESENT;
            end else if (!free_q) begin
              res_sts_d = cwt_pkg::STS_FULL;
            end else begin
              res_has_d          = 1'b1;
              res_idx_d          = free_idx_q;
              used_d[free_idx_q] = 1'b1;
              if ((free_idx_q == IDX_W'(0)) || (free_idx_q == IDX_W'(1))) begin
                preset_d[free_idx_q[0]] = 1'b0;
              end
            end
          end
          default: begin
            if (!hit_q) res_sts_d = cwt_pkg::STS_NOT_FOUND;
            else        used_d[hit_idx_q] = 1'b0;
          end
        endcase
        state_d = S_REPLY;
      end

      S_REPLY: begin
        // Wait for the result register to free up
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d  = 1'b1;
          rsp_sts_d  = res_sts_q;
          rsp_slot_d = res_has_q ? slot_ext[SLOT_W-1:0] : '0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
      used_q    <= ENTRIES'(2'b11);
      preset_q  <= 2'b11;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      used_q    <= used_d;
      preset_q  <= preset_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    pin_q      <= pin_d;
    id_bad_q   <= id_bad_d;
    pin_bad_q  <= pin_bad_d;
    rd_cnt_q   <= rd_cnt_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_pin_q  <= hit_pin_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    res_sts_q  <= res_sts_d;
    res_idx_q  <= res_idx_d;
    res_has_q  <= res_has_d;
    rsp_sts_q  <= rsp_sts_d;
    rsp_slot_q <= rsp_slot_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = rsp_vld_q;
  assign rsp_o.ok     = (rsp_sts_q == cwt_pkg::STS_OK);
  assign rsp_o.status = rsp_sts_q;
  assign rsp_o.slot   = rsp_slot_q;

`ifndef ASSERT_OFF
  // An add only ever writes a slot that the scan found unused
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !used_q[free_idx_q])
    else $error("add writes a used slot");

  // A match recorded by the scan always points at a used slot
  a_hit_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE && hit_q) |-> used_q[hit_idx_q])
    else $error("match on an unused slot");

  // A successful add marks exactly one more slot used
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> ($countones(used_q) == $countones($past(used_q)) + 1))
    else $error("used count not bumped by add");

  // The read counter never runs past the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_cnt_q <= CNT_W'(ENTRIES)))
    else $error("scan counter out of range");
`endif

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the credential whitelist table
// Drives check, verify, add and remove requests over the request channel.
// Each response beat is compared with the result of a behavioral copy of the
// table, updated as every request beat is taken.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Table sizes
  localparam int ENTRIES   = cwt_pkg::ENTRIES;
  localparam int ID_CHARS  = cwt_pkg::ID_CHARS;
  localparam int PIN_CHARS = cwt_pkg::PIN_CHARS;
  localparam int ID_IN_W   = cwt_pkg::ID_IN_W;
  localparam int PIN_IN_W  = cwt_pkg::PIN_IN_W;
  localparam int ID_W      = cwt_pkg::ID_W;
  localparam int PIN_W     = cwt_pkg::PIN_W;
  localparam int SLOT_W    = cwt_pkg::SLOT_W;

  // Run shape
  localparam int TOTAL_ITEMS = 1550;
  localparam int POOL        = 40;
  localparam int PHASE1_AT   = 520;
  localparam int PHASE2_AT   = 1040;
  localparam int HOLD_AT     = 1150;
  localparam int HOLD_LEN    = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 2 * (ENTRIES + 4);

  typedef struct packed {
    cwt_pkg::op_e        op;
    logic [ID_IN_W-1:0]  id;
    logic [PIN_IN_W-1:0] pin;
  } request_t;

  typedef struct packed {
    logic              ok;
    cwt_pkg::status_e  status;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  cwt_req_if req_bus ();
  cwt_rsp_if rsp_bus ();

  credential_whitelist_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the credential table
  logic [ID_W-1:0]  cred_id   [ENTRIES];
  logic [PIN_W-1:0] cred_pin  [ENTRIES];
  logic             cred_used [ENTRIES];

  request_t req_backlog[$];
  reply_t   pending_replies[$];

  int n_req_sent;
  int n_req_acc;
  int n_errors;
  int quiet_cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  bit hold_done;

  logic [ID_IN_W-1:0]  pool_id  [POOL];
  logic [PIN_IN_W-1:0] pool_pin [POOL];

  // --------------------------------------------------------------------------
  // Behavioral table
  // --------------------------------------------------------------------------
  function automatic bit id_holds_n(input logic [ID_W-1:0] v);
    for (int k = 0; k < ID_CHARS; k++) begin
      if (v[8*k +: 8] == cwt_pkg::CH_N) return 1'b1;
    end
    return 1'b0;
  endfunction

  // only the leading characters may not be 'n'; the last one may
  function automatic bit pin_lead_holds_n(input logic [PIN_W-1:0] v);
    for (int k = 1; k < PIN_CHARS; k++) begin
      if (v[8*k +: 8] == cwt_pkg::CH_N) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      cred_id[i]   = {ID_CHARS{cwt_pkg::CH_N}};
      cred_pin[i]  = {PIN_CHARS{cwt_pkg::CH_N}};
      cred_used[i] = 1'b0;
    end
    cred_id[0]   = cwt_pkg::PRESET_ID0[ID_W-1:0];
    cred_pin[0]  = cwt_pkg::PRESET_PIN0[PIN_W-1:0];
    cred_used[0] = 1'b1;
    cred_id[1]   = cwt_pkg::PRESET_ID1[ID_W-1:0];
    cred_pin[1]  = cwt_pkg::PRESET_PIN1[PIN_W-1:0];
    cred_used[1] = 1'b1;
  endfunction

  // lowest used slot holding the ID, -1 when none or the ID has an 'n'
  function automatic int lookup_slot(input logic [ID_W-1:0] id);
    if (id_holds_n(id)) return -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cred_used[i] && cred_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic reply_t whitelist_predict(input request_t r);
    logic [ID_W-1:0]  id;
    logic [PIN_W-1:0] pin;
    cwt_pkg::status_e sts;
    int               hit;
    int               slot;
    int               free_slot;
    reply_t           rep;
    id   = r.id[ID_W-1:0];
    pin  = r.pin[PIN_W-1:0];
    sts  = cwt_pkg::STS_OK;
    slot = -1;
    hit  = lookup_slot(id);
    case (r.op)
      cwt_pkg::OP_CHECK: begin
        if (hit < 0) sts = cwt_pkg::STS_NOT_FOUND;
        else slot = hit;
      end
      cwt_pkg::OP_VERIFY: begin
        if (hit < 0) begin
          sts = cwt_pkg::STS_NOT_FOUND;
        end else begin
          slot = hit;
          if (pin != cred_pin[hit] || pin_lead_holds_n(pin)) sts = cwt_pkg::STS_PIN_MISMATCH;
        end
      end
      cwt_pkg::OP_ADD: begin
        if (id_holds_n(id) || pin_lead_holds_n(pin)) begin
          sts = cwt_pkg::STS_BAD_FORMAT;
        end else if (hit >= 0) begin
          sts = cwt_pkg::STS_PRESENT;
        end else begin
          free_slot = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!cred_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            sts = cwt_pkg::STS_FULL;
          end else begin
            cred_id[free_slot]   = id;
            cred_pin[free_slot]  = pin;
            cred_used[free_slot] = 1'b1;
            slot                 = free_slot;
          end
        end
      end
      default: begin
        if (hit < 0) begin
          sts = cwt_pkg::STS_NOT_FOUND;
        end else begin
          cred_id[hit]   = {ID_CHARS{cwt_pkg::CH_N}};
          cred_pin[hit]  = {PIN_CHARS{cwt_pkg::CH_N}};
          cred_used[hit] = 1'b0;
          slot           = hit;
        end
      end
    endcase
    rep.ok     = (sts == cwt_pkg::STS_OK);
    rep.status = sts;
    rep.slot   = (slot < 0) ? '0 : SLOT_W'(slot);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == cwt_pkg::CH_N) ? 8'h6F : c;
  endfunction

  function automatic logic [ID_IN_W-1:0] random_id();
    logic [ID_IN_W-1:0] v;
    for (int k = 0; k < 8; k++) v[8*k +: 8] = plain_char();
    return v;
  endfunction

  // a quarter of the PINs are short: last character 'n'
  function automatic logic [PIN_IN_W-1:0] random_pin();
    logic [PIN_IN_W-1:0] v;
    for (int k = 0; k < 5; k++) v[8*k +: 8] = plain_char();
    if ($urandom_range(3) == 0) v[7:0] = cwt_pkg::CH_N;
    return v;
  endfunction

  function automatic logic [PIN_IN_W-1:0] noise_pin();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic void queue_request(input cwt_pkg::op_e op,
                                        input logic [ID_IN_W-1:0] id,
                                        input logic [PIN_IN_W-1:0] pin);
    request_t r;
    r.op  = op;
    r.id  = id;
    r.pin = pin;
    req_backlog.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle rates per phase: sender-light, receiver-light, then none
  always_comb begin
    if (n_req_acc < PHASE1_AT) begin
      tx_idle_pct = 20;
      rx_idle_pct = 65;
    end else if (n_req_acc < PHASE2_AT) begin
      tx_idle_pct = 65;
      rx_idle_pct = 20;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: offers the next beat once the current one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_bus.valid || n_req_acc == n_req_sent) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req_bus.opcode    <= req_backlog[0].op;
          req_bus.id_chars  <= req_backlog[0].id;
          req_bus.pin_chars <= req_backlog[0].pin;
          req_bus.valid     <= 1'b1;
          n_req_sent        <= n_req_sent + 1;
          void'(req_backlog.pop_front());
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response ready: random stalls plus one long hold-off to back up the block
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_req_acc >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left     = hold_left - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on request beats, compare on response beats
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    reply_t want;
    request_t taken;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
        taken.op  = cwt_pkg::op_e'(req_bus.opcode);
        taken.id  = req_bus.id_chars;
        taken.pin = req_bus.pin_chars;
        pending_replies.push_back(whitelist_predict(taken));
        n_req_acc <= n_req_acc + 1;
        moved = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        moved = 1'b1;
        if (pending_replies.size() == 0) begin
          $display("%0t: response beat with none expected: ok=%0b status=%0d slot=%0d",
                   $time, rsp_bus.ok, rsp_bus.status, rsp_bus.slot);
          n_errors++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_bus.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, rsp_bus.ok);
            n_errors++;
          end
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, rsp_bus.status);
            n_errors++;
          end
          if (rsp_bus.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, got %0d",
                     $time, want.slot, rsp_bus.slot);
            n_errors++;
          end
        end
      end
      // watchdog on cycles with no beat on either channel
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int                  kind;
    int                  k;
    int                  pos;
    cwt_pkg::op_e        op;
    logic [ID_IN_W-1:0]  id;
    logic [PIN_IN_W-1:0] pin;

    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.opcode    = cwt_pkg::OP_CHECK;
    req_bus.id_chars  = '0;
    req_bus.pin_chars = '0;
    rsp_bus.ready     = 1'b0;
    n_req_sent        = 0;
    n_req_acc         = 0;
    n_errors          = 0;
    quiet_cycles      = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    table_reset();

    // ID pool: the two presets plus random well-formed credentials
    pool_id[0]  = cwt_pkg::PRESET_ID0;
    pool_pin[0] = cwt_pkg::PRESET_PIN0;
    pool_id[1]  = cwt_pkg::PRESET_ID1;
    pool_pin[1] = cwt_pkg::PRESET_PIN1;
    for (int i = 2; i < POOL; i++) begin
      pool_id[i]  = random_id();
      pool_pin[i] = random_pin();
    end

    // Directed: presets, bad format, short PIN, remove/re-add, extremes
    queue_request(cwt_pkg::OP_CHECK,  cwt_pkg::PRESET_ID0, '0);
    queue_request(cwt_pkg::OP_CHECK,  cwt_pkg::PRESET_ID1, '0);
    queue_request(cwt_pkg::OP_VERIFY, cwt_pkg::PRESET_ID0, cwt_pkg::PRESET_PIN0);
    queue_request(cwt_pkg::OP_VERIFY, cwt_pkg::PRESET_ID0, cwt_pkg::PRESET_PIN1);
    queue_request(cwt_pkg::OP_CHECK,  "4517660n", '0);
    queue_request(cwt_pkg::OP_VERIFY, "12345678", "12345");
    queue_request(cwt_pkg::OP_ADD,    "12n45678", "12345");
    queue_request(cwt_pkg::OP_ADD,    "12345678", "n2345");
    queue_request(cwt_pkg::OP_ADD,    "12345678", "1234n");
    queue_request(cwt_pkg::OP_VERIFY, "12345678", "1234n");
    queue_request(cwt_pkg::OP_VERIFY, "12345678", "12345");
    queue_request(cwt_pkg::OP_ADD,    cwt_pkg::PRESET_ID0, "22222");
    queue_request(cwt_pkg::OP_REMOVE, cwt_pkg::PRESET_ID1, '0);
    queue_request(cwt_pkg::OP_REMOVE, cwt_pkg::PRESET_ID1, '0);
    queue_request(cwt_pkg::OP_ADD,    '0, '0);
    queue_request(cwt_pkg::OP_ADD,    '1, '1);
    queue_request(cwt_pkg::OP_REMOVE, "12345678", '1);
    queue_request(cwt_pkg::OP_ADD,    '1, '1);
    queue_request(cwt_pkg::OP_CHECK,  "nnnnnnnn", '0);
    queue_request(cwt_pkg::OP_REMOVE, "0000000n", '0);

    // Random part built from short sequences
    while (req_backlog.size() < TOTAL_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        // fill burst: more adds than the table has slots
        for (int n = 0; n < 20; n++) begin
          k = $urandom_range(POOL - 1);
          queue_request(cwt_pkg::OP_ADD, pool_id[k], pool_pin[k]);
        end
      end else if (kind < 25) begin
        // drain burst
        for (int n = 0; n < 12; n++) begin
          k = $urandom_range(POOL - 1);
          queue_request(cwt_pkg::OP_REMOVE, pool_id[k], noise_pin());
        end
      end else if (kind < 80) begin
        // mixed well-formed traffic, mostly on known IDs
        for (int n = 0; n < 20; n++) begin
          k   = $urandom_range(POOL - 1);
          op  = cwt_pkg::op_e'($urandom_range(3));
          id  = ($urandom_range(9) == 0) ? random_id() : pool_id[k];
          pin = pool_pin[k];
          if (op == cwt_pkg::OP_VERIFY && $urandom_range(3) == 0)
            pin = pin ^ (40'h1 << $urandom_range(PIN_IN_W - 1));
          else if (op == cwt_pkg::OP_CHECK || op == cwt_pkg::OP_REMOVE)
            pin = noise_pin();
          queue_request(op, id, pin);
        end
      end else if (kind < 90) begin
        // broken requests: an 'n' in the ID or in a leading PIN character
        for (int n = 0; n < 10; n++) begin
          k   = $urandom_range(POOL - 1);
          id  = pool_id[k];
          pin = pool_pin[k];
          if ($urandom_range(1) == 0) begin
            pos = $urandom_range(ID_CHARS - 1);
            id[8*pos +: 8] = cwt_pkg::CH_N;
          end else begin
            pos = $urandom_range(PIN_CHARS - 1, 1);
            pin[8*pos +: 8] = cwt_pkg::CH_N;
          end
          queue_request(cwt_pkg::op_e'($urandom_range(3)), id, pin);
        end
      end else begin
        // raw noise over every field bit
        for (int n = 0; n < 10; n++) begin
          queue_request(cwt_pkg::op_e'($urandom_range(3)),
                        {32'($urandom), 32'($urandom)}, noise_pin());
        end
      end
    end

    // Reset: held low from the start, released on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all beats to go in and all results to come back
    while (req_backlog.size() != 0 || req_bus.valid || pending_replies.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cwt_pkg.sv
design/cwt_req_if.sv
design/cwt_rsp_if.sv
design/cwt_mem.sv
design/credential_whitelist_table.sv
bench/testbench.sv
